/* rtl/olmsr_pkg.sv */
// Shared types, widths and constants for the open-loop motor speed ramp.
`default_nettype none
package olmsr_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int ALIGN_W  = 16;
  localparam int RAMP_W   = 16;
  localparam int PERIOD_W = 20;
  localparam int DUTY_W   = 7;
  localparam int PHASE_W  = 2;
  localparam int RPM_W    = 24;
  localparam int PROG_W   = 10;   // permille progress, 0..999

  // Stream and config port widths
  localparam int IN_DATA_W  = TIME_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_FLD_W  = PERIOD_W + DUTY_W + PHASE_W + RPM_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = PERIOD_W;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ALIGN_TIME   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_TIME    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_PERIOD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FINAL_PERIOD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ALIGN_DUTY   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_START_DUTY   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FINAL_DUTY   = 3'd6;

  // Register reset values
  localparam logic [ALIGN_W-1:0]  ALIGN_TIME_RST   = 16'd500;
  localparam logic [RAMP_W-1:0]   RAMP_TIME_RST    = 16'd3000;
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 20'd10000;
  localparam logic [PERIOD_W-1:0] FINAL_PERIOD_RST = 20'd1500;
  localparam logic [DUTY_W-1:0]   ALIGN_DUTY_RST   = 7'd10;
  localparam logic [DUTY_W-1:0]   START_DUTY_RST   = 7'd15;
  localparam logic [DUTY_W-1:0]   FINAL_DUTY_RST   = 7'd40;

  // Input mode codes
  localparam logic [IN_USER_W-1:0] MODE_START  = 1'b0;
  localparam logic [IN_USER_W-1:0] MODE_UPDATE = 1'b1;

  // Ramp phase codes
  typedef enum logic [PHASE_W-1:0] {
    PHASE_ALIGN = 2'd0,
    PHASE_ACCEL = 2'd1,
    PHASE_RUN   = 2'd2
  } phase_t;

  // Arithmetic constants
  localparam int PERMILLE = 1000;
  localparam int RPM_NUM  = 60000000;
  localparam logic [RPM_W-1:0] RPM_MAX = 24'hFFFFFF;

  // Shared divider: dividend width and bit counts per division
  localparam int NUM_W    = 30;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int PROG_LEN = 26;   // ramp_el * 1000 < 2^26
  localparam int DUTY_LEN = 17;   // duty span * progress < 2^17
  localparam int RPM_LEN  = 26;   // 60e6 < 2^26

  // x / 1000 for x < 2^30 as ((x >> 3) * ceil(2^34 / 125)) >> 34
  localparam int RECIP_IN_W   = NUM_W - 3;
  localparam int RECIP_W      = 28;
  localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;
  localparam int RECIP_SHIFT  = 34;
  localparam int RECIP_PROD_W = RECIP_IN_W + RECIP_W;

endpackage
`default_nettype wire

/* rtl/open_loop_motor_speed_ramp_top.sv */
// Sequence: accept, phase pick, then for accelerating items the progress
//   division and the period and duty scalings, then the rpm division (skipped
//   when the step period is zero), then the output register.
// Throughput: one item at a time; ready returns once the result is registered.
//   The divisions use the shared radix-2 divider, one quotient bit per cycle;
//   the two scalings by 1000 use one reciprocal multiply each.
// Reset (rst, synchronous): registers take their defaults, origin clears, idle.
`default_nettype none
module open_loop_motor_speed_ramp_top #(
  parameter int STEPS_PER_REV = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [olmsr_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] now_ms
  input  wire logic [olmsr_pkg::IN_USER_W-1:0]   s_tuser,   // [0] mode
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [19:0] step_period_us, [26:20] duty_pct, [28:27] ramp_phase,
  // [52:29] electrical_rpm, [55:53] zero
  output logic [olmsr_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [olmsr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [olmsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import olmsr_pkg::*;

  localparam int SW    = $clog2(STEPS_PER_REV + 1);
  localparam int DEN_W = PERIOD_W + SW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_PROG_LD, ST_PROG_DIV, ST_PER_LD, ST_PER_DIV,
    ST_DUTY_LD, ST_DUTY_DIV, ST_RPM_LD, ST_RPM_DIV, ST_DONE
  } state_t;

  // Configuration registers
  logic [ALIGN_W-1:0]  align_time;
  logic [RAMP_W-1:0]   ramp_time;
  logic [PERIOD_W-1:0] start_period;
  logic [PERIOD_W-1:0] final_period;
  logic [DUTY_W-1:0]   align_duty;
  logic [DUTY_W-1:0]   start_duty;
  logic [DUTY_W-1:0]   final_duty;

  // Profile and working state
  state_t              state;
  logic [TIME_W-1:0]   origin;
  logic [TIME_W-1:0]   elapsed;
  logic                is_start;
  logic [RAMP_W-1:0]   ramp_el;
  logic [PROG_W-1:0]   progress;
  logic [PERIOD_W-1:0] pspan;
  logic [DUTY_W-1:0]   dspan;
  logic [PERIOD_W-1:0] work_period;
  logic [DUTY_W-1:0]   work_duty;
  phase_t              work_phase;
  logic [RPM_W-1:0]    work_rpm;

  // Shared divider registers
  logic [NUM_W-1:0]    div_num;
  logic [NUM_W-1:0]    div_quo;
  logic [DEN_W-1:0]    div_rem;
  logic [DEN_W-1:0]    div_den;
  logic [CNT_W-1:0]    div_cnt;

  // Combinational helpers
  logic [DEN_W:0]      trial;
  logic                trial_ge;
  logic [DEN_W:0]      trial_diff;
  logic [DEN_W-1:0]    div_rem_next;
  logic [NUM_W-1:0]    div_quo_next;
  logic [TIME_W-1:0]   ramp_el_full;
  logic [PROG_LEN-1:0] prog_prod;
  logic [NUM_W-1:0]    per_prod;
  logic [DUTY_LEN-1:0] duty_prod;
  logic [DEN_W-1:0]    rev_den;
  logic [RECIP_PROD_W-1:0]             recip_prod;
  logic [RECIP_PROD_W-RECIP_SHIFT-1:0] recip_q;

  assign s_tready = (state == ST_IDLE);

  // One restoring divide step per cycle
  always_comb begin
    trial        = {div_rem, div_num[NUM_W-1]};
    trial_ge     = (trial >= {1'b0, div_den});
    trial_diff   = trial - {1'b0, div_den};
    div_rem_next = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    div_quo_next = {div_quo[NUM_W-2:0], trial_ge};
  end

  // div_num / 1000 by reciprocal multiply
  assign recip_prod = RECIP_PROD_W'(div_num[NUM_W-1:NUM_W-RECIP_IN_W])
                    * RECIP_PROD_W'(RECIP_125);
  assign recip_q    = recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];

  // Operand products and time since align end
  assign ramp_el_full = elapsed - TIME_W'(align_time);
  assign prog_prod    = PROG_LEN'(ramp_el) * PROG_LEN'(PERMILLE);
  assign per_prod     = NUM_W'(pspan) * NUM_W'(progress);
  assign duty_prod    = DUTY_LEN'(dspan) * DUTY_LEN'(progress);
  assign rev_den      = DEN_W'(work_period) * DEN_W'(STEPS_PER_REV);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      align_time   <= ALIGN_TIME_RST;
      ramp_time    <= RAMP_TIME_RST;
      start_period <= START_PERIOD_RST;
      final_period <= FINAL_PERIOD_RST;
      align_duty   <= ALIGN_DUTY_RST;
      start_duty   <= START_DUTY_RST;
      final_duty   <= FINAL_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALIGN_TIME:   align_time   <= cfg_wdata[ALIGN_W-1:0];
        REG_RAMP_TIME:    ramp_time    <= cfg_wdata[RAMP_W-1:0];
        REG_START_PERIOD: start_period <= cfg_wdata[PERIOD_W-1:0];
        REG_FINAL_PERIOD: final_period <= cfg_wdata[PERIOD_W-1:0];
        REG_ALIGN_DUTY:   align_duty   <= cfg_wdata[DUTY_W-1:0];
        REG_START_DUTY:   start_duty   <= cfg_wdata[DUTY_W-1:0];
        REG_FINAL_DUTY:   final_duty   <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, shared divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      origin   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Output register: load a finished item, clear on handshake
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tdata  <= {{OUT_PAD_W{1'b0}}, work_rpm, work_phase, work_duty, work_period};
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            is_start <= (s_tuser == MODE_START);
            elapsed  <= s_tdata - origin;
            if (s_tuser == MODE_START) begin
              origin <= s_tdata;
            end
            state <= ST_EVAL;
          end
        end
        // Pick the phase from the mode and the elapsed time
        ST_EVAL: begin
          if (is_start || (elapsed < TIME_W'(align_time))) begin
            work_phase  <= PHASE_ALIGN;
            work_period <= start_period;
            work_duty   <= align_duty;
            state       <= ST_RPM_LD;
          end else if (ramp_el_full >= TIME_W'(ramp_time)) begin
            work_phase  <= PHASE_RUN;
            work_period <= final_period;
            work_duty   <= final_duty;
            state       <= ST_RPM_LD;
          end else begin
            work_phase <= PHASE_ACCEL;
            ramp_el    <= ramp_el_full[RAMP_W-1:0];
            state      <= ST_PROG_LD;
          end
        end
        // progress = ramp_el * 1000 / ramp_time
        ST_PROG_LD: begin
          div_num <= NUM_W'(prog_prod) << (NUM_W - PROG_LEN);
          div_den <= DEN_W'(ramp_time);
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= CNT_W'(PROG_LEN - 1);
          pspan   <= (start_period > final_period) ? (start_period - final_period) : '0;
          dspan   <= (final_duty > start_duty) ? (final_duty - start_duty) : '0;
          state   <= ST_PROG_DIV;
        end
        ST_PROG_DIV: begin
          div_num <= div_num << 1;
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            progress <= div_quo_next[PROG_W-1:0];
            state    <= ST_PER_LD;
          end
        end
        // period = start - pspan * progress / 1000
        ST_PER_LD: begin
          div_num <= per_prod;
          state   <= ST_PER_DIV;
        end
        ST_PER_DIV: begin
          work_period <= start_period - recip_q[PERIOD_W-1:0];
          state       <= ST_DUTY_LD;
        end
        // duty = start + dspan * progress / 1000
        ST_DUTY_LD: begin
          div_num <= NUM_W'(duty_prod);
          state   <= ST_DUTY_DIV;
        end
        ST_DUTY_DIV: begin
          work_duty <= start_duty + recip_q[DUTY_W-1:0];
          state     <= ST_RPM_LD;
        end
        // rpm = 60e6 / (period * steps per rev), zero period gives zero
        ST_RPM_LD: begin
          if (work_period == '0) begin
            work_rpm <= '0;
            state    <= ST_DONE;
          end else begin
            div_num <= NUM_W'(RPM_NUM) << (NUM_W - RPM_LEN);
            div_den <= rev_den;
            div_rem <= '0;
            div_quo <= '0;
            div_cnt <= CNT_W'(RPM_LEN - 1);
            state   <= ST_RPM_DIV;
          end
        end
        ST_RPM_DIV: begin
          div_num <= div_num << 1;
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            work_rpm <= (div_quo_next > NUM_W'(RPM_MAX)) ? RPM_MAX
                                                         : div_quo_next[RPM_W-1:0];
            state    <= ST_DONE;
          end
        end
        // Hand over once the output register is free
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/olmsr_chk.sv */
// Port-level checker for the speed ramp top level, with its bind.
`default_nettype none
module olmsr_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [olmsr_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import olmsr_pkg::*;

  logic [PERIOD_W-1:0] out_period;
  logic [RPM_W-1:0]    out_rpm;

  assign out_period = m_tdata[PERIOD_W-1:0];
  assign out_rpm    = m_tdata[OUT_FLD_W-1:OUT_FLD_W-RPM_W];

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted item");

  // A fresh result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the block was idle");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Zero period reports zero rpm, nonzero period never does
  a_rpm_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_period == '0) == (out_rpm == '0)))
    else $error("rpm does not match a zero period");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind open_loop_motor_speed_ramp_top olmsr_chk u_olmsr_chk (.*);
`default_nettype wire
